// ===== rtl/core/sfs_pkg.sv =====
// Package: shared widths, codes, reset values, state and status types, filter coefficients.
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MODE_W     = 2;
  localparam int ALPHA_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [MODE_W-1:0] MODE_AVG = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EMA = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 1'b1;

  localparam logic [MODE_W-1:0]  MODE_RST  = MODE_EMA;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd6554;

  localparam int EMA_FRAC_W = 8;
  localparam int EMA_W      = SAMPLE_W + EMA_FRAC_W;
  localparam int EMA_DIFF_W = EMA_W + 1;
  localparam int EMA_PROD_W = EMA_DIFF_W + ALPHA_W + 1;

  localparam int SG_TAPS   = 11;
  localparam int SG_FILL_W = $clog2(SG_TAPS + 1);
  localparam int SG_K_W    = $clog2(SG_TAPS);
  localparam int SG_SUM_W  = SAMPLE_W + $clog2(SG_TAPS);
  localparam int SG_COEF_W = 8;
  localparam int SG_PROD_W = SG_COEF_W + SAMPLE_W + 1;
  localparam int SG_ACC_W  = SG_PROD_W + 3;

  // floor(n / 429) as (n * SG_RECIP) >> SG_RECIP_SH, exact for n below 2^25
  localparam int                    SG_RECIP_W  = 26;
  localparam int                    SG_RECIP_SH = 34;
  localparam logic [SG_RECIP_W-1:0] SG_RECIP    = 26'd40046316;

  localparam logic signed [SG_COEF_W-1:0] SG_COEF [SG_TAPS] = '{
    -8'sd36, 8'sd9, 8'sd44, 8'sd69, 8'sd84, 8'sd89,
    8'sd84, 8'sd69, 8'sd44, 8'sd9, -8'sd36
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EMA_MUL,
    ST_EMA_ADD,
    ST_SG_MAC,
    ST_SG_SUM,
    ST_SG_SCALE,
    ST_DIV_LOAD,
    ST_DIV_WAIT,
    ST_PUSH
  } sfs_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sfs_div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/sfs_stream_if.sv =====
// Interfaces: sample input channel and filtered result channel.
`timescale 1ns / 1ps
`default_nettype none

interface sfs_sample_if import sfs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface sfs_result_if import sfs_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] filtered_out;

  modport source (output valid, output filtered_out, input ready);
  modport sink (input valid, input filtered_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sfs_tap_cell.sv =====
// Tap cell: one sample register of a shift or rotate chain.
`timescale 1ns / 1ps
`default_nettype none

module sfs_tap_cell import sfs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                shift_en,
  input  wire logic [SAMPLE_W-1:0] d,
  output logic      [SAMPLE_W-1:0] q
);

  logic [SAMPLE_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== rtl/core/sfs_divider.sv =====
// Divider: unsigned restoring division, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sfs_divider import sfs_pkg::*; #(
  parameter int DVD_W = 27,
  parameter int DVS_W = 9
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output sfs_div_stat_t         stat,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W:0]   rem_diff;
  logic             ge;

  assign rem_sh   = {rem_r, quo_r[DVD_W-1]};
  assign rem_diff = rem_sh - {1'b0, dvs_r};
  assign ge       = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      rem_nxt = ge ? rem_diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

// ===== rtl/core/selectable_smoothing_filter_top.sv =====
// Top level: selectable moving average, exponential and Savitzky-Golay smoother.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    sample_in    [15:0] unsigned
//   out_chan  out  valid/ready    filtered_out [15:0] unsigned
//   cfg_*     in   cfg_we         cfg_index [0], cfg_wdata [15:0]
//
// Exponential mode: the first sample goes straight to the output load; later samples
// pass through accept, multiply, add, output load.
// Moving average and Savitzky-Golay fill: accept, then the sum is divided by the fill count
// in the 20-step divider, then load.
// Savitzky-Golay full: 11 rotations of the tap chain, sum, reciprocal scale (zero if negative), load.
// Reset is synchronous; tap cells are not reset, all counters and running sums are.
// A result waiting at the output does not block the next transfer in; a finished
// result holds until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module selectable_smoothing_filter_top import sfs_pkg::*; #(
  parameter int AVG_TAPS = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  sfs_sample_if.sink                 in_chan,
  sfs_result_if.source               out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AVG_FILL_W = $clog2(AVG_TAPS + 1);
  localparam int AVG_SUM_W  = SAMPLE_W + $clog2(AVG_TAPS);
  localparam int DVD_W      = (AVG_SUM_W > SG_SUM_W) ? AVG_SUM_W : SG_SUM_W;
  localparam int DVS_W      = (AVG_FILL_W > SG_FILL_W) ? AVG_FILL_W : SG_FILL_W;

  sfs_state_t state_r, state_nxt;

  logic [MODE_W-1:0]               mode_r, mode_nxt;
  logic [ALPHA_W-1:0]              alpha_r, alpha_nxt;
  logic [AVG_SUM_W-1:0]            avg_sum_r, avg_sum_nxt;
  logic [AVG_FILL_W-1:0]           avg_fill_r, avg_fill_nxt;
  logic [EMA_W-1:0]                ema_r, ema_nxt;
  logic                            ema_started_r, ema_started_nxt;
  logic [SG_SUM_W-1:0]             sg_sum_r, sg_sum_nxt;
  logic [SG_FILL_W-1:0]            sg_fill_r, sg_fill_nxt;
  logic [SG_K_W-1:0]               k_r, k_nxt;
  logic [SAMPLE_W-1:0]             sample_r, sample_nxt;
  logic signed [EMA_PROD_W-1:0]    ema_prod_r, ema_prod_nxt;
  logic signed [SG_PROD_W-1:0]     mac_prod_r, mac_prod_nxt;
  logic signed [SG_ACC_W-1:0]      acc_r, acc_nxt;
  logic [DVD_W-1:0]                dvd_r, dvd_nxt;
  logic [DVS_W-1:0]                dvs_r, dvs_nxt;
  logic [SAMPLE_W-1:0]             res_r, res_nxt;
  logic [SAMPLE_W-1:0]             out_data_r, out_data_nxt;
  logic                            out_valid_r, out_valid_nxt;

  logic                  in_ready;
  logic                  accept;
  logic                  avg_shift;
  logic                  sg_shift;
  logic                  sg_rot;
  logic                  div_start;
  logic                  out_load;
  logic [SAMPLE_W-1:0]   x;
  logic [SAMPLE_W-1:0]   avg_q [AVG_TAPS];
  logic [SAMPLE_W-1:0]   sg_q [SG_TAPS];
  logic                  avg_full;
  logic [AVG_SUM_W-1:0]  avg_sum_add;
  logic [AVG_FILL_W-1:0] avg_fill_inc;
  logic [SG_FILL_W-1:0]  sg_fill_inc;
  logic [SG_SUM_W-1:0]   sg_sum_add;

  logic signed [EMA_DIFF_W-1:0] ema_diff;
  logic signed [EMA_PROD_W-1:0] ema_prod;
  logic signed [EMA_PROD_W-1:0] ema_step;
  logic signed [EMA_PROD_W-1:0] ema_sum;
  logic [EMA_W-1:0]             ema_new;
  logic signed [SG_PROD_W-1:0]  mac_prod;
  logic signed [SG_ACC_W-1:0]   acc_sum;

  logic [SG_ACC_W+SG_RECIP_W-2:0] sg_scaled;
  logic [SAMPLE_W-1:0]            sg_sat;

  sfs_div_stat_t        div_stat;
  logic [DVD_W-1:0]     div_quo;
  logic [SAMPLE_W-1:0]  div_sat;

  assign x      = in_chan.sample_in;
  assign accept = in_chan.valid && in_ready;

  // tap chains
  for (genvar i = 0; i < AVG_TAPS; i++) begin : g_avg
    if (i == 0) begin : g_head
      sfs_tap_cell u_cell (.clk(clk), .shift_en(avg_shift), .d(x), .q(avg_q[i]));
    end else begin : g_body
      sfs_tap_cell u_cell (.clk(clk), .shift_en(avg_shift), .d(avg_q[i-1]), .q(avg_q[i]));
    end
  end

  for (genvar i = 0; i < SG_TAPS; i++) begin : g_sg
    if (i == 0) begin : g_head
      sfs_tap_cell u_cell (
        .clk(clk), .shift_en(sg_shift || sg_rot),
        .d(sg_rot ? sg_q[SG_TAPS-1] : x), .q(sg_q[i])
      );
    end else begin : g_body
      sfs_tap_cell u_cell (
        .clk(clk), .shift_en(sg_shift || sg_rot), .d(sg_q[i-1]), .q(sg_q[i])
      );
    end
  end

  sfs_divider #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(div_start),
    .dividend(dvd_r),
    .divisor(dvs_r),
    .stat(div_stat),
    .quotient(div_quo)
  );

  // arithmetic
  assign avg_full     = avg_fill_r == AVG_FILL_W'(AVG_TAPS);
  assign avg_sum_add  = avg_sum_r + AVG_SUM_W'(x)
                        - (avg_full ? AVG_SUM_W'(avg_q[AVG_TAPS-1]) : '0);
  assign avg_fill_inc = avg_full ? avg_fill_r : avg_fill_r + 1'b1;
  assign sg_fill_inc  = (sg_fill_r == SG_FILL_W'(SG_TAPS)) ? sg_fill_r : sg_fill_r + 1'b1;
  assign sg_sum_add   = sg_sum_r + SG_SUM_W'(x);

  assign ema_diff = $signed({1'b0, sample_r, {EMA_FRAC_W{1'b0}}}) - $signed({1'b0, ema_r});
  assign ema_prod = ema_diff * $signed({1'b0, alpha_r});
  assign ema_step = ema_prod_r >>> ALPHA_W;
  assign ema_sum  = $signed({{(EMA_PROD_W-EMA_W){1'b0}}, ema_r}) + ema_step;
  assign ema_new  = ema_sum[EMA_PROD_W-1] ? '0 : ema_sum[EMA_W-1:0];

  assign mac_prod = SG_COEF[k_r] * $signed({1'b0, sg_q[SG_TAPS-1]});
  assign acc_sum  = acc_r + SG_ACC_W'(mac_prod_r);

  assign sg_scaled = acc_r[SG_ACC_W-2:0] * SG_RECIP;
  assign sg_sat    = (sg_scaled[SG_ACC_W+SG_RECIP_W-2:SG_RECIP_SH+SAMPLE_W] != '0) ? '1
                     : sg_scaled[SG_RECIP_SH+SAMPLE_W-1:SG_RECIP_SH];

  assign div_sat = (div_quo[DVD_W-1:SAMPLE_W] != '0) ? '1 : div_quo[SAMPLE_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (mode_r)
            MODE_AVG: state_nxt = ST_DIV_LOAD;
            MODE_EMA: state_nxt = ema_started_r ? ST_EMA_MUL : ST_PUSH;
            default:  state_nxt = (sg_fill_inc == SG_FILL_W'(SG_TAPS)) ? ST_SG_MAC
                                                                        : ST_DIV_LOAD;
          endcase
        end
      end
      ST_EMA_MUL: state_nxt = ST_EMA_ADD;
      ST_EMA_ADD: state_nxt = ST_PUSH;
      ST_SG_MAC: begin
        if (k_r == SG_K_W'(SG_TAPS - 1)) begin
          state_nxt = ST_SG_SUM;
        end
      end
      ST_SG_SUM:   state_nxt = acc_sum[SG_ACC_W-1] ? ST_PUSH : ST_SG_SCALE;
      ST_SG_SCALE: state_nxt = ST_PUSH;
      ST_DIV_LOAD: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    avg_shift = 1'b0;
    sg_shift  = 1'b0;
    sg_rot    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        avg_shift = in_chan.valid && (mode_r == MODE_AVG);
        sg_shift  = in_chan.valid && (mode_r != MODE_AVG) && (mode_r != MODE_EMA);
      end
      ST_SG_MAC:   sg_rot    = 1'b1;
      ST_DIV_LOAD: div_start = 1'b1;
      ST_PUSH:     out_load  = !out_valid_r || out_chan.ready;
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    mode_nxt        = mode_r;
    alpha_nxt       = alpha_r;
    avg_sum_nxt     = avg_sum_r;
    avg_fill_nxt    = avg_fill_r;
    ema_nxt         = ema_r;
    ema_started_nxt = ema_started_r;
    sg_sum_nxt      = sg_sum_r;
    sg_fill_nxt     = sg_fill_r;
    k_nxt           = k_r;
    sample_nxt      = sample_r;
    ema_prod_nxt    = ema_prod_r;
    mac_prod_nxt    = mac_prod_r;
    acc_nxt         = acc_r;
    dvd_nxt         = dvd_r;
    dvs_nxt         = dvs_r;
    res_nxt         = res_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;

    if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:  mode_nxt  = cfg_wdata[MODE_W-1:0];
        CFG_ALPHA: alpha_nxt = cfg_wdata[ALPHA_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          sample_nxt = x;
          case (mode_r)
            MODE_AVG: begin
              avg_sum_nxt  = avg_sum_add;
              avg_fill_nxt = avg_fill_inc;
              dvd_nxt      = DVD_W'(avg_sum_add);
              dvs_nxt      = DVS_W'(avg_fill_inc);
            end
            MODE_EMA: begin
              if (!ema_started_r) begin
                ema_started_nxt = 1'b1;
                ema_nxt         = {x, {EMA_FRAC_W{1'b0}}};
                res_nxt         = x;
              end
            end
            default: begin
              sg_fill_nxt  = sg_fill_inc;
              if (sg_fill_r != SG_FILL_W'(SG_TAPS)) begin
                sg_sum_nxt = sg_sum_add;
              end
              dvd_nxt      = DVD_W'(sg_sum_add);
              dvs_nxt      = DVS_W'(sg_fill_inc);
              k_nxt        = '0;
              acc_nxt      = '0;
              mac_prod_nxt = '0;
            end
          endcase
        end
      end
      ST_EMA_MUL: ema_prod_nxt = ema_prod;
      ST_EMA_ADD: begin
        ema_nxt = ema_new;
        res_nxt = ema_new[EMA_W-1:EMA_FRAC_W];
      end
      ST_SG_MAC: begin
        mac_prod_nxt = mac_prod;
        acc_nxt      = acc_sum;
        k_nxt        = k_r + 1'b1;
      end
      ST_SG_SUM: begin
        acc_nxt = acc_sum;
        res_nxt = '0;
      end
      ST_SG_SCALE: res_nxt = sg_sat;
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          res_nxt = div_sat;
        end
      end
      default: begin
      end
    endcase

    if (out_load) begin
      out_data_nxt  = res_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      mode_r        <= MODE_RST;
      alpha_r       <= ALPHA_RST;
      avg_sum_r     <= '0;
      avg_fill_r    <= '0;
      ema_r         <= '0;
      ema_started_r <= 1'b0;
      sg_sum_r      <= '0;
      sg_fill_r     <= '0;
      k_r           <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      mode_r        <= mode_nxt;
      alpha_r       <= alpha_nxt;
      avg_sum_r     <= avg_sum_nxt;
      avg_fill_r    <= avg_fill_nxt;
      ema_r         <= ema_nxt;
      ema_started_r <= ema_started_nxt;
      sg_sum_r      <= sg_sum_nxt;
      sg_fill_r     <= sg_fill_nxt;
      k_r           <= k_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    sample_r   <= sample_nxt;
    ema_prod_r <= ema_prod_nxt;
    mac_prod_r <= mac_prod_nxt;
    acc_r      <= acc_nxt;
    dvd_r      <= dvd_nxt;
    dvs_r      <= dvs_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.filtered_out = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/sfs_checker.sv =====
// Checker: port-level properties of the smoothing filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sfs_checker import sfs_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [SAMPLE_W-1:0] out_data
);

  logic [1:0] pend_r, pend_nxt;

  always_comb begin
    pend_nxt = pend_r;
    case ({in_valid && in_ready, out_valid && out_ready})
      2'b10:   pend_nxt = pend_r + 1'b1;
      2'b01:   pend_nxt = pend_r - 1'b1;
      default: pend_nxt = pend_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer in before work started");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending input");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many items in flight");

endmodule

bind selectable_smoothing_filter_top sfs_checker u_sfs_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_chan.valid),
  .in_ready(in_chan.ready),
  .out_valid(out_chan.valid),
  .out_ready(out_chan.ready),
  .out_data(out_chan.filtered_out)
);

`default_nettype wire

// ===== verif/selectable_smoothing_filter_top_tb.sv =====
// Testbench: selectable smoothing filter checked against a cycle-free filter predictor.
`timescale 1ns / 1ps

module selectable_smoothing_filter_top_tb;
  import sfs_pkg::*;

  localparam int AVG_WINDOW    = 11;
  localparam int SG_WINDOW     = 11;
  localparam int SG_DIVISOR    = 429;
  localparam int SETTLE_CYCLES = 48;
  localparam int IDLE_LIMIT    = 4000;
  localparam int RANDOM_ITEMS  = 1220;
  localparam int SG_WEIGHT [SG_WINDOW] = '{-36, 9, 44, 69, 84, 89, 84, 69, 44, 9, -36};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sfs_sample_if in_if ();
  sfs_result_if out_if ();

  selectable_smoothing_filter_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state
  logic [MODE_W-1:0]   mdl_mode;
  logic [ALPHA_W-1:0]  mdl_alpha;
  logic [SAMPLE_W-1:0] avg_taps [AVG_WINDOW];
  logic [19:0]         avg_total;
  int                  avg_pos;
  int                  avg_count;
  logic [EMA_W-1:0]    ema_level;
  bit                  ema_live;
  logic [SAMPLE_W-1:0] sg_taps [SG_WINDOW];
  int                  sg_pos;
  int                  sg_count;

  logic [SAMPLE_W-1:0] pending_levels [$];
  int                  fault_count;
  int                  idle_cycles;
  int                  ready_left;
  bit                  gaps_on;
  bit                  stalls_on;

  function automatic logic [SAMPLE_W-1:0] sat_level(longint v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] smooth_level(logic [SAMPLE_W-1:0] x);
    longint target;
    longint diff;
    longint step;
    longint nxt;
    longint acc;
    logic [SAMPLE_W-1:0] y;
    case (mdl_mode)
      MODE_AVG: begin
        if (avg_count < AVG_WINDOW) avg_count++;
        else avg_total = avg_total - avg_taps[avg_pos];
        avg_taps[avg_pos] = x;
        avg_total = avg_total + x;
        avg_pos = (avg_pos + 1) % AVG_WINDOW;
        y = sat_level(longint'(avg_total) / avg_count);
      end
      MODE_EMA: begin
        target = longint'(x) <<< EMA_FRAC_W;
        if (!ema_live) begin
          ema_live = 1'b1;
          ema_level = target[EMA_W-1:0];
          y = x;
        end else begin
          diff = target - longint'(ema_level);
          step = (diff * longint'(mdl_alpha)) >>> 16;
          nxt = longint'(ema_level) + step;
          if (nxt < 0) nxt = 0;
          ema_level = nxt[EMA_W-1:0];
          y = sat_level(nxt >>> EMA_FRAC_W);
        end
      end
      default: begin
        sg_taps[sg_pos] = x;
        sg_pos = (sg_pos + 1) % SG_WINDOW;
        if (sg_count < SG_WINDOW) sg_count++;
        acc = 0;
        if (sg_count < SG_WINDOW) begin
          for (int i = 0; i < sg_count; i++) acc += sg_taps[i];
          y = sat_level(acc / sg_count);
        end else begin
          for (int i = 0; i < SG_WINDOW; i++)
            acc += SG_WEIGHT[i] * longint'(sg_taps[(sg_pos + i) % SG_WINDOW]);
          y = sat_level(acc / SG_DIVISOR);
        end
      end
    endcase
    return y;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_levels.size() == 0) begin
        $error("unexpected result filtered_out=%0d", out_if.filtered_out);
        fault_count++;
      end else if (out_if.filtered_out !== pending_levels[0]) begin
        $error("filtered_out mismatch: expected %0d, actual %0d",
               pending_levels[0], out_if.filtered_out);
        fault_count++;
        void'(pending_levels.pop_front());
      end else begin
        void'(pending_levels.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result-side backpressure
  always @(negedge clk) begin
    if (ready_left > 0) begin
      ready_left--;
    end else if (!stalls_on) begin
      out_if.ready = 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_if.ready = 1'b0;
      ready_left = pick_gap();
    end else begin
      out_if.ready = 1'b1;
      ready_left = $urandom_range(0, 6);
    end
  end

  task automatic send_sample(input logic [SAMPLE_W-1:0] x);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      in_if.sample_in = SAMPLE_W'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.sample_in = x;
    do @(posedge clk); while (!in_if.ready);
    pending_levels.push_back(smooth_level(x));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_MODE:  mdl_mode = data[MODE_W-1:0];
      CFG_ALPHA: mdl_alpha = data[ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic test_ema_first();
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'hAAAA);
    send_sample(16'h5555);
  endtask

  task automatic test_ema_alpha_edges();
    write_reg(CFG_ALPHA, 16'h0000);
    send_sample(16'h0000);
    send_sample(16'h1234);
    write_reg(CFG_ALPHA, 16'hFFFF);
    send_sample(16'hFFFF);
    write_reg(CFG_ALPHA, 16'h0001);
    send_sample(16'h0000);
  endtask

  task automatic test_moving_average();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_AVG));
    for (int i = 0; i < AVG_WINDOW + 1; i++)
      send_sample((i % 3 == 2) ? 16'h0000 : 16'hFFFF);
  endtask

  task automatic test_savgol();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_SG));
    for (int i = 0; i < SG_WINDOW; i++)
      send_sample((i == 0 || i == SG_WINDOW - 1) ? 16'hFFFF : 16'h0000);
    // unused mode code, then the SG code, upper data bits set
    write_reg(CFG_MODE, 16'hFFFF);
    send_sample(16'h0000);
    write_reg(CFG_MODE, 16'hFFFE);
    send_sample(16'hFFFF);
  endtask

  task automatic test_random();
    int sent;
    int burst;
    int shape;
    int tmp;
    bit flip;
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] prev;
    logic [SAMPLE_W-1:0] hi_v;
    logic [SAMPLE_W-1:0] lo_v;
    sent = 0;
    prev = 16'h8000;
    while (sent < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      write_reg(CFG_MODE, {14'($urandom), 2'($urandom_range(0, 3))});
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 5))
          0: write_reg(CFG_ALPHA, 16'h0000);
          1: write_reg(CFG_ALPHA, 16'h0001);
          2: write_reg(CFG_ALPHA, 16'hFFFF);
          3: write_reg(CFG_ALPHA, 16'd6554);
          default: write_reg(CFG_ALPHA, 16'($urandom));
        endcase
      end
      burst = $urandom_range(12, 60);
      shape = $urandom_range(0, 3);
      flip = $urandom_range(0, 1);
      for (int k = 0; k < burst; k++) begin
        case (shape)
          0: x = SAMPLE_W'($urandom);
          1: begin
            case ($urandom_range(0, 4))
              0: x = 16'h0000;
              1: x = 16'hFFFF;
              2: x = 16'hAAAA;
              3: x = 16'h5555;
              default: x = SAMPLE_W'($urandom);
            endcase
          end
          2: begin
            tmp = int'(prev) + int'($urandom_range(0, 2048)) - 1024;
            if (tmp < 0) tmp = 0;
            if (tmp > 65535) tmp = 65535;
            x = SAMPLE_W'(tmp);
          end
          default: begin
            hi_v = 16'hFFFF - SAMPLE_W'($urandom_range(0, 255));
            lo_v = SAMPLE_W'($urandom_range(0, 255));
            if ((k % SG_WINDOW) < 2) x = flip ? lo_v : hi_v;
            else x = flip ? hi_v : lo_v;
          end
        endcase
        send_sample(x);
        prev = x;
        sent++;
        if ($urandom_range(0, 99) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.sample_in = '0;
    out_if.ready = 1'b0;
    ready_left = 0;
    idle_cycles = 0;
    fault_count = 0;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    mdl_mode = MODE_EMA;
    mdl_alpha = 16'd6554;
    avg_total = '0;
    avg_pos = 0;
    avg_count = 0;
    ema_level = '0;
    ema_live = 1'b0;
    sg_pos = 0;
    sg_count = 0;
    for (int i = 0; i < AVG_WINDOW; i++) avg_taps[i] = '0;
    for (int i = 0; i < SG_WINDOW; i++) sg_taps[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_ema_first();
    test_ema_alpha_edges();
    test_moving_average();
    test_savgol();
    test_random();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
